[hw/rtl/erpd_pkg.sv]
// ----------------------------------------------------------------------------
// Escape run-length page decoder package
// Item types, queue entry type and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package erpd_pkg;

  localparam logic [7:0] ESC_BYTE = 8'hED;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;
  localparam logic [1:0] PH_COUNT = 2'd3;

  localparam logic REG_IN_LIMIT  = 1'b0;
  localparam logic REG_OUT_LIMIT = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    logic [13:0] write_offset;
    logic [7:0]  write_value;
    logic [7:0]  run_length;
    logic        last_of_item;
    logic        block_full;
  } cmd_item_t;

  typedef struct packed {
    logic      two;
    cmd_item_t r0;
    cmd_item_t r1;
  } cmd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hw/rtl/erpd_front.sv]
// ----------------------------------------------------------------------------
// Escape run-length decoder front
// Accepts compressed bytes, tracks the escape phase and positions, and turns
// each byte that completes a token into a queue entry of one or two write commands.
// ----------------------------------------------------------------------------
module erpd_front import erpd_pkg::*; #(
  parameter int PAGE_BYTES = 16384
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_valid,
  output logic          byte_stall,
  input  byte_item_t    byte_item,
  input  logic [15:0]   in_limit,
  input  logic [14:0]   out_limit,
  input  queue_status_t qstat,
  output logic          push,
  output cmd_entry_t    push_entry
);

  localparam logic [14:0] PAGE_LIM = 15'(PAGE_BYTES);

  logic [1:0]  phase, phase_next, phase_eff;
  logic [7:0]  pending, pending_next, pending_eff;
  logic [14:0] out_pos, out_pos_next, out_eff;
  logic [15:0] in_pos, in_pos_next, in_eff;
  logic [14:0] lim, room, out_p1, out_p2, run_len;
  logic        accept, ignore, second;
  logic [7:0]  b;

  assign byte_stall = qstat.full;
  assign accept     = byte_valid && !qstat.full;
  assign b          = byte_item.in_byte;

  assign phase_eff   = byte_item.first ? PH_IDLE : phase;
  assign pending_eff = byte_item.first ? 8'd0 : pending;
  assign out_eff     = byte_item.first ? 15'd0 : out_pos;
  assign in_eff      = byte_item.first ? 16'd0 : in_pos;

  assign lim     = (out_limit > PAGE_LIM) ? PAGE_LIM : out_limit;
  assign ignore  = (in_eff >= in_limit) || (out_eff >= lim);
  assign room    = lim - out_eff;
  assign out_p1  = out_eff + 15'd1;
  assign out_p2  = out_eff + 15'd2;
  assign second  = out_p1 < lim;
  assign run_len = ({7'd0, pending_eff} < room) ? {7'd0, pending_eff} : room;

  always_comb begin
    phase_next   = phase;
    pending_next = pending;
    out_pos_next = out_pos;
    in_pos_next  = in_pos;
    push         = 1'b0;
    push_entry   = '0;
    if (accept) begin
      phase_next   = phase_eff;
      pending_next = pending_eff;
      out_pos_next = out_eff;
      in_pos_next  = in_eff;
      if (!ignore) begin
        in_pos_next = in_eff + 16'd1;
        unique case (phase_eff)
          PH_IDLE: begin
            if (b != ESC_BYTE) begin
              push         = 1'b1;
              push_entry.r0 = '{out_eff[13:0], b, 8'd1, 1'b1, out_p1 >= lim};
              out_pos_next = out_p1;
            end else begin
              phase_next = PH_ONE;
            end
          end
          PH_ONE: begin
            if (b != ESC_BYTE) begin
              push           = 1'b1;
              push_entry.two = second;
              push_entry.r0  = '{out_eff[13:0], ESC_BYTE, 8'd1, !second, !second};
              push_entry.r1  = '{out_p1[13:0], b, 8'd1, 1'b1, out_p2 >= lim};
              out_pos_next   = second ? out_p2 : out_p1;
              phase_next     = PH_IDLE;
            end else begin
              phase_next = PH_TWO;
            end
          end
          PH_TWO: begin
            pending_next = b;
            phase_next   = PH_COUNT;
          end
          default: begin
            if (pending_eff != 8'd0) begin
              push          = 1'b1;
              push_entry.r0 = '{out_eff[13:0], b, run_len[7:0], 1'b1, run_len == room};
              out_pos_next  = out_eff + run_len;
            end
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      pending <= 8'd0;
      out_pos <= 15'd0;
      in_pos  <= 16'd0;
    end else begin
      phase   <= phase_next;
      pending <= pending_next;
      out_pos <= out_pos_next;
      in_pos  <= in_pos_next;
    end
  end

endmodule

[hw/rtl/erpd_queue.sv]
// ----------------------------------------------------------------------------
// Escape run-length decoder command queue
// A short register queue of command entries between the front and the back.
// ----------------------------------------------------------------------------
module erpd_queue import erpd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_entry_t    push_entry,
  input  logic          pop,
  output cmd_entry_t    head,
  output queue_status_t qstat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_entry_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = count == FULL_CNT;
  assign qstat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && qstat.full))
    else $error("Item pushed into a full queue.");
  assert property (@(posedge clk) disable iff (rst) !(pop && qstat.empty))
    else $error("Item popped from an empty queue.");
  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("Queue count beyond its depth.");

endmodule

[hw/rtl/erpd_back.sv]
// ----------------------------------------------------------------------------
// Escape run-length decoder back
// Takes queue entries apart into single write commands and holds each one in
// the output register until it is taken.
// ----------------------------------------------------------------------------
module erpd_back import erpd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cmd_entry_t    head,
  input  queue_status_t qstat,
  output logic          pop,
  output logic          cmd_valid,
  input  logic          cmd_stall,
  output cmd_item_t     cmd_item
);

  logic sub, load;

  assign load = !qstat.empty && (!cmd_valid || !cmd_stall);
  assign pop  = load && (sub || !head.two);

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_item <= sub ? head.r1 : head.r0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      sub       <= 1'b0;
    end else begin
      if (load) begin
        cmd_valid <= 1'b1;
        sub       <= !pop;
      end else if (!cmd_stall) begin
        cmd_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) sub |-> !qstat.empty)
    else $error("Second command pending without a queue entry.");
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> cmd_item.run_length != 8'd0)
    else $error("Write command with zero run length.");

endmodule

[hw/rtl/escape_rle_page_decoder_top.sv]
// ----------------------------------------------------------------------------
// Escape run-length page decoder
// Expands escape run-length coded bytes into write commands for one page.
// ----------------------------------------------------------------------------
// One compressed byte is accepted in every cycle while the command queue has
// room; byte_stall rises only when the queue is full. Each write command
// leaves through the output register, so a byte that gives a literal pair
// can yield two commands and the queue of QUEUE_DEPTH entries absorbs the
// difference; the output side sets the sustained rate at one command per
// cycle while cmd_stall is low. Both the queue and the output are registered.
module escape_rle_page_decoder_top import erpd_pkg::*; #(
  parameter int PAGE_BYTES  = 16384,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  byte_item_t  byte_item,
  output logic        cmd_valid,
  input  logic        cmd_stall,
  output cmd_item_t   cmd_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]   in_limit;
  logic [14:0]   out_limit;
  logic          push, pop;
  cmd_entry_t    push_entry, head;
  queue_status_t qstat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_OUT_LIMIT) ? {17'd0, out_limit} : {16'd0, in_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_limit  <= 16'd65534;
      out_limit <= 15'd16384;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_IN_LIMIT) begin
        in_limit <= pwdata[15:0];
      end else begin
        out_limit <= pwdata[14:0];
      end
    end
  end

  erpd_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .in_limit   (in_limit),
    .out_limit  (out_limit),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  erpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  erpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item)
  );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Escape run-length page decoder testbench
// Feeds compressed bytes through the item handshake under several limit
// settings, predicts every write command from a local decoder model and
// checks each command field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_top;
  import erpd_pkg::*;

  localparam int PAGE_BYTES   = 16384;
  localparam int DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  byte_item_t  byte_item = '0;
  logic        cmd_valid;
  logic        cmd_stall = 1'b0;
  cmd_item_t   cmd_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  escape_rle_page_decoder_top #(
    .PAGE_BYTES(PAGE_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .byte_item(byte_item),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item(cmd_item),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Decoder state as the block should hold it.
  logic [15:0] in_lim    = 16'd65534;
  logic [14:0] out_lim   = 15'd16384;
  logic [1:0]  esc_phase = PH_IDLE;
  logic [7:0]  run_count = '0;
  logic [14:0] out_pos   = '0;
  logic [15:0] in_pos    = '0;

  byte_item_t feed_q [$];
  cmd_item_t  cmd_q [$];
  cmd_item_t  got_cmd;
  cmd_item_t  want_cmd;
  int         n_errors = 0;
  int         n_items = 0;
  int         n_checked = 0;
  bit         calm = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  function automatic int page_write(logic [7:0] value, int want);
    cmd_item_t c;
    int lim;
    int room;
    int len;
    lim = (out_lim > PAGE_BYTES) ? PAGE_BYTES : out_lim;
    if (out_pos >= lim || want == 0) return 0;
    room = lim - out_pos;
    len = (want < room) ? want : room;
    c.write_offset = out_pos[13:0];
    c.write_value  = value;
    c.run_length   = len[7:0];
    c.last_of_item = 1'b0;
    out_pos = out_pos + len[14:0];
    c.block_full = (out_pos >= lim);
    cmd_q.push_back(c);
    return 1;
  endfunction

  function automatic void decode_byte(byte_item_t it);
    cmd_item_t c;
    int lim;
    int n;
    n = 0;
    if (it.first) begin
      esc_phase = PH_IDLE;
      run_count = '0;
      out_pos = '0;
      in_pos = '0;
    end
    lim = (out_lim > PAGE_BYTES) ? PAGE_BYTES : out_lim;
    if (in_pos >= in_lim || out_pos >= lim) return;
    in_pos = in_pos + 16'd1;
    case (esc_phase)
      PH_IDLE: begin
        if (it.in_byte != ESC_BYTE) n += page_write(it.in_byte, 1);
        else esc_phase = PH_ONE;
      end
      PH_ONE: begin
        if (it.in_byte != ESC_BYTE) begin
          n += page_write(ESC_BYTE, 1);
          n += page_write(it.in_byte, 1);
          esc_phase = PH_IDLE;
        end else begin
          esc_phase = PH_TWO;
        end
      end
      PH_TWO: begin
        run_count = it.in_byte;
        esc_phase = PH_COUNT;
      end
      default: begin
        n += page_write(it.in_byte, run_count);
        esc_phase = PH_IDLE;
      end
    endcase
    if (n > 0) begin
      c = cmd_q.pop_back();
      c.last_of_item = 1'b1;
      cmd_q.push_back(c);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      gap_left <= 0;
    end else if (!byte_valid || !byte_stall) begin
      if (gap_left > 0) begin
        byte_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        byte_valid <= 1'b0;
        gap_left <= $urandom_range(0, 6);
      end else if (feed_q.size() > 0) begin
        byte_valid <= 1'b1;
        byte_item <= feed_q.pop_front();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // A single long hold-off lets the command queue fill and back up the input.
  always @(posedge clk) begin
    if (rst) begin
      cmd_stall <= 1'b0;
    end else if (hold_left > 0) begin
      cmd_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_checked >= 200 && feed_q.size() > 16) begin
      cmd_stall <= 1'b1;
      hold_done <= 1'b1;
      hold_left <= 79;
    end else if (stall_left > 0) begin
      cmd_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      cmd_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      cmd_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) decode_byte(byte_item);
      if (cmd_valid && !cmd_stall) begin
        got_cmd = cmd_item;
        if (cmd_q.size() == 0) begin
          $error("unexpected write command: offset %0d value %0d length %0d",
                 got_cmd.write_offset, got_cmd.write_value, got_cmd.run_length);
          n_errors++;
        end else begin
          want_cmd = cmd_q.pop_front();
          n_checked <= n_checked + 1;
          if (got_cmd.write_offset != want_cmd.write_offset) begin
            $error("write_offset: expected %0d, got %0d",
                   want_cmd.write_offset, got_cmd.write_offset);
            n_errors++;
          end
          if (got_cmd.write_value != want_cmd.write_value) begin
            $error("write_value: expected %0d, got %0d",
                   want_cmd.write_value, got_cmd.write_value);
            n_errors++;
          end
          if (got_cmd.run_length != want_cmd.run_length) begin
            $error("run_length: expected %0d, got %0d",
                   want_cmd.run_length, got_cmd.run_length);
            n_errors++;
          end
          if (got_cmd.last_of_item != want_cmd.last_of_item) begin
            $error("last_of_item: expected %0d, got %0d",
                   want_cmd.last_of_item, got_cmd.last_of_item);
            n_errors++;
          end
          if (got_cmd.block_full != want_cmd.block_full) begin
            $error("block_full: expected %0d, got %0d",
                   want_cmd.block_full, got_cmd.block_full);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] in_val, input logic [14:0] out_val);
    logic [31:0] rd;
    apb_access(1'b1, {REG_IN_LIMIT, 2'b00}, {16'd0, in_val}, rd);
    in_lim = in_val;
    apb_access(1'b1, {REG_OUT_LIMIT, 2'b00}, {17'd0, out_val}, rd);
    out_lim = out_val;
    apb_access(1'b0, {REG_IN_LIMIT, 2'b00}, '0, rd);
    if (rd[15:0] != in_val) begin
      $error("in_limit: expected %0d, got %0d", in_val, rd[15:0]);
      n_errors++;
    end
    apb_access(1'b0, {REG_OUT_LIMIT, 2'b00}, '0, rd);
    if (rd[14:0] != out_val) begin
      $error("out_limit: expected %0d, got %0d", out_val, rd[14:0]);
      n_errors++;
    end
  endtask

  task automatic wait_idle();
    while (feed_q.size() != 0 || byte_valid || cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_byte(input logic [7:0] v, input logic f);
    feed_q.push_back(byte_item_t'{in_byte: v, first: f});
    n_items++;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == ESC_BYTE);
    return v;
  endfunction

  // Mostly well-formed tokens: literals, escaped runs and literal pairs,
  // with some raw noise that may restart the block in mid-sequence.
  task automatic queue_block(input int n_tok);
    int k;
    int pick;
    int r;
    logic f;
    logic [7:0] cnt;
    for (k = 0; k < n_tok; k++) begin
      f = (k == 0);
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        queue_byte(plain_byte(), f);
      end else if (pick < 13) begin
        r = $urandom_range(0, 9);
        cnt = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'd1 :
              8'($urandom_range(0, 255));
        queue_byte(ESC_BYTE, f);
        queue_byte(ESC_BYTE, 1'b0);
        queue_byte(cnt, 1'b0);
        queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 17) begin
        queue_byte(ESC_BYTE, f);
        queue_byte(plain_byte(), 1'b0);
      end else begin
        queue_byte(8'($urandom_range(0, 255)), f || ($urandom_range(0, 15) == 0));
      end
    end
  endtask

  initial begin
    int ph;
    int target;
    logic [15:0] il;
    logic [14:0] ol;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(ESC_BYTE, 1'b0);
    wait_idle();

    set_limits(16'd65534, 15'd2);
    queue_byte(8'h42, 1'b0);
    queue_byte(8'h11, 1'b1);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(8'h10, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h11, 1'b1);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(8'h22, 1'b0);
    queue_byte(ESC_BYTE, 1'b1);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h33, 1'b0);
    queue_byte(8'h44, 1'b0);
    queue_byte(8'h66, 1'b0);
    wait_idle();

    set_limits(16'd3, 15'd1);
    queue_byte(ESC_BYTE, 1'b1);
    queue_byte(ESC_BYTE, 1'b0);
    queue_byte(8'h05, 1'b0);
    queue_byte(8'h77, 1'b0);
    queue_byte(8'h99, 1'b1);
    queue_byte(8'h12, 1'b0);
    wait_idle();

    set_limits(16'd0, 15'd16384);
    queue_byte(8'h5A, 1'b1);
    queue_byte(ESC_BYTE, 1'b0);
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        il = 16'd65534;
        ol = 15'd16384;
      end else begin
        il = ($urandom_range(0, 2) == 0) ? 16'd65534 : 16'($urandom_range(1, 300));
        ol = ($urandom_range(0, 4) == 0) ? 15'($urandom_range(1, 16384)) :
             15'($urandom_range(1, 700));
      end
      set_limits(il, ol);
      if (ph == 5) calm = 1'b1;
      target = n_items + 175;
      while (n_items < target) queue_block($urandom_range(2, 25));
      wait_idle();
    end

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/erpd_pkg.sv
hw/rtl/erpd_front.sv
hw/rtl/erpd_queue.sv
hw/rtl/erpd_back.sv
hw/rtl/escape_rle_page_decoder_top.sv
test/tb_top.sv
